// ===== src/bst_preorder_sequence_check_top_macros.svh =====
// Assertion helpers used by the checker of this block.
// Each expects signals named clk and rst_n in scope.
`ifndef BST_PREORDER_SEQUENCE_CHECK_TOP_MACROS_SVH
`define BST_PREORDER_SEQUENCE_CHECK_TOP_MACROS_SVH

// Same-cycle implication.
`define BPSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpsc assertion failed");

// Next-cycle implication.
`define BPSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpsc assertion failed");

`endif

// ===== src/bpsc_pkg.sv =====
`timescale 1ns / 1ps

package bpsc_pkg;

  typedef logic signed [31:0] key_t;
  typedef logic [1:0] status_t;

  localparam status_t STATUS_VALID        = 2'd0;
  localparam status_t STATUS_NOT_PREORDER = 2'd1;
  localparam status_t STATUS_OVERFLOW     = 2'd2;

  localparam key_t INT_MIN = 32'sh8000_0000;
  localparam key_t INT_MAX = 32'sh7FFF_FFFF;

endpackage

// ===== src/bst_preorder_sequence_check_top.sv =====
`timescale 1ns / 1ps
// Flow: an accepted beat goes to S_SCAN, then via S_WAIT back to S_SCAN per bound pair
// popped (one stack RAM read each), then to S_DONE, which loads the output register;
// a key rejected or ignored after a failure goes straight to S_DONE; a stalled out_ready
// adds its wait. in_ready is low while a key is at work, so no new beat is taken before
// the last result is loaded. Reset: rst_n synchronous active low; clears state, status
// and output valid; sets the stack to the single full-range pair. No RAM clearing pass.
module bst_preorder_sequence_check_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_key_value,
  input  logic        in_end_of_sequence,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_check_status,
  output logic        out_sequence_done
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [AW-1:0] TOP_MAX = AW'(STACK_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                state_r;
  bpsc_pkg::key_t        key_r;
  logic                  last_r;
  bpsc_pkg::status_t     sticky_r;
  logic [AW-1:0]         top_r;      // index of the top pair
  bpsc_pkg::key_t        top_lo_r;   // top pair lives in registers
  bpsc_pkg::key_t        top_hi_r;
  bpsc_pkg::key_t        bottom_lo_r; // entry 0 lower bound when it is not the top
  logic                  out_valid_r;
  bpsc_pkg::status_t     out_status_r;
  logic                  out_done_r;

  logic                  pop;
  logic                  ram_we;
  logic [63:0]           ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [63:0]           ram_rdata;
  bpsc_pkg::key_t        in_key;

  assign in_key = $signed(in_key_value);

  // the shared compare: key above the top upper bound pops (bottom pair never popped)
  assign pop       = (top_r != '0) && (key_r > top_hi_r);
  assign ram_we    = (state_r == S_SCAN) && !pop && (top_r != '0) && (top_r != TOP_MAX);
  assign ram_wdata = {key_r, top_hi_r};
  assign ram_raddr = top_r - AW'(1);

  bpsc_ram #(
    .WIDTH (64),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (top_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sticky_r    <= bpsc_pkg::STATUS_VALID;
      top_r       <= '0;
      top_lo_r    <= bpsc_pkg::INT_MIN;
      top_hi_r    <= bpsc_pkg::INT_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            key_r  <= in_key;
            last_r <= in_end_of_sequence;
            if (sticky_r != bpsc_pkg::STATUS_VALID) begin
              state_r <= S_DONE;
            end else if (in_key < top_lo_r) begin
              sticky_r <= bpsc_pkg::STATUS_NOT_PREORDER;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pop) begin
            top_r   <= top_r - AW'(1);
            state_r <= S_WAIT;
          end else if (top_r == TOP_MAX) begin
            // no pops happened, so the stack is untouched
            sticky_r <= bpsc_pkg::STATUS_OVERFLOW;
            state_r  <= S_DONE;
          end else begin
            if (top_r == '0) begin
              bottom_lo_r <= key_r;
            end
            top_hi_r <= key_r;
            top_r    <= top_r + AW'(1);
            state_r  <= S_DONE;
          end
        end
        S_WAIT: begin
          if (top_r == '0) begin
            top_lo_r <= bottom_lo_r;
            top_hi_r <= bpsc_pkg::INT_MAX;
          end else begin
            top_lo_r <= $signed(ram_rdata[63:32]);
            top_hi_r <= $signed(ram_rdata[31:0]);
          end
          state_r <= S_SCAN;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_status_r <= sticky_r;
            out_done_r   <= last_r;
            if (last_r) begin
              sticky_r <= bpsc_pkg::STATUS_VALID;
              top_r    <= '0;
              top_lo_r <= bpsc_pkg::INT_MIN;
              top_hi_r <= bpsc_pkg::INT_MAX;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_check_status  = out_status_r;
  assign out_sequence_done = out_done_r;

endmodule

// ===== src/bpsc_ram.sv =====
`timescale 1ns / 1ps

module bpsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bpsc_checker.sv =====
`timescale 1ns / 1ps
`include "bst_preorder_sequence_check_top_macros.svh"

module bpsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_key_value,
  input logic        in_end_of_sequence,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_check_status,
  input logic        out_sequence_done
);

  logic [32:0] in_beat;
  logic [2:0]  out_beat;

  assign in_beat  = {in_key_value, in_end_of_sequence};
  assign out_beat = {out_check_status, out_sequence_done};

  // a stalled input beat holds
  `BPSC_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_beat))

  // a stalled result beat holds
  `BPSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_beat))

  // status code is never the unused one
  `BPSC_ASSERT_NOW(a_status_code, out_valid, out_check_status <= bpsc_pkg::STATUS_OVERFLOW)

  // the block is busy right after taking a beat
  `BPSC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a fresh result only follows a cycle of work
  `BPSC_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready))

endmodule

bind bst_preorder_sequence_check_top bpsc_checker u_bpsc_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH        = 64;
  localparam int ITEMS        = 1100;
  localparam int CALM_TAIL    = 150;
  localparam int HOLD_AT      = 350;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int N_DIRECTED   = 20;

  typedef struct packed {
    bpsc_pkg::status_t status;
    logic              done;
  } verdict_t;

  typedef struct packed {
    bpsc_pkg::key_t    key;
    logic              eos;
    logic              typed;
    bpsc_pkg::status_t status;
  } dir_row_t;

  logic        clk                = 1'b0;
  logic        rst_n              = 1'b0;
  logic        in_valid           = 1'b0;
  logic        in_ready;
  logic [31:0] in_key_value       = '0;
  logic        in_end_of_sequence = 1'b0;
  logic        out_valid;
  logic        out_ready          = 1'b0;
  logic [1:0]  out_check_status;
  logic        out_sequence_done;

  bst_preorder_sequence_check_top #(.STACK_DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_key_value      (in_key_value),
    .in_end_of_sequence(in_end_of_sequence),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_check_status  (out_check_status),
    .out_sequence_done (out_sequence_done)
  );

  always #5 clk = ~clk;

  // shadow of the bound-pair stack
  bpsc_pkg::key_t    lo_stk [DEPTH];
  bpsc_pkg::key_t    hi_stk [DEPTH];
  int                depth_used;
  bpsc_pkg::status_t run_status;

  verdict_t verdict_q [$];

  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int send_run  = 0;
  int fail_cnt  = 0;
  int beats_in  = 0;
  int seq_ok    = 0;
  int seq_bad   = 0;
  int seq_ovf   = 0;
  int quiet     = 0;

  // directed rows; typed status only where it is obvious
  dir_row_t dir_rows [N_DIRECTED] = '{
    '{32'sd0,            1'b1, 1'b1, bpsc_pkg::STATUS_VALID},        // lone key after reset
    '{bpsc_pkg::INT_MIN, 1'b1, 1'b1, bpsc_pkg::STATUS_VALID},
    '{bpsc_pkg::INT_MAX, 1'b1, 1'b1, bpsc_pkg::STATUS_VALID},
    '{32'sd5,            1'b0, 1'b1, bpsc_pkg::STATUS_VALID},
    '{32'sd7,            1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{32'sd3,            1'b0, 1'b1, bpsc_pkg::STATUS_NOT_PREORDER}, // below lower bound 5
    '{32'sd100,          1'b1, 1'b1, bpsc_pkg::STATUS_NOT_PREORDER}, // sticky through end
    '{32'sd10,           1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{32'sd5,            1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{32'sd10,           1'b0, 1'b0, bpsc_pkg::STATUS_VALID},        // equals upper bound
    '{32'sd10,           1'b0, 1'b0, bpsc_pkg::STATUS_VALID},        // equals upper bound again
    '{bpsc_pkg::INT_MAX, 1'b0, 1'b0, bpsc_pkg::STATUS_VALID},        // pops to bottom pair
    '{bpsc_pkg::INT_MAX, 1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{bpsc_pkg::INT_MIN, 1'b1, 1'b0, bpsc_pkg::STATUS_VALID},
    '{bpsc_pkg::INT_MIN, 1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{bpsc_pkg::INT_MIN, 1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{-32'sd1,           1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{32'sd1,            1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{32'sh5555_5555,    1'b0, 1'b0, bpsc_pkg::STATUS_VALID},
    '{32'shAAAA_AAAA,    1'b1, 1'b0, bpsc_pkg::STATUS_VALID}
  };

  function automatic void clear_stack();
    foreach (lo_stk[i]) begin
      lo_stk[i] = '0;
      hi_stk[i] = '0;
    end
    lo_stk[0]  = bpsc_pkg::INT_MIN;
    hi_stk[0]  = bpsc_pkg::INT_MAX;
    depth_used = 1;
  endfunction

  // advance the shadow stack by one key, return the status for that beat
  function automatic bpsc_pkg::status_t preorder_step(input bpsc_pkg::key_t key,
                                                      input logic eos);
    int                top;
    bpsc_pkg::status_t verdict;
    if (run_status == bpsc_pkg::STATUS_VALID) begin
      top = depth_used - 1;
      if (key < lo_stk[top]) begin
        run_status = bpsc_pkg::STATUS_NOT_PREORDER;
      end else begin
        while (top > 0 && key > hi_stk[top]) top--;
        if (top + 2 > DEPTH) begin
          run_status = bpsc_pkg::STATUS_OVERFLOW;
        end else begin
          lo_stk[top + 1] = lo_stk[top];
          hi_stk[top + 1] = key;
          lo_stk[top]     = key;
          depth_used      = top + 2;
        end
      end
    end
    verdict = run_status;
    if (eos) begin
      clear_stack();
      run_status = bpsc_pkg::STATUS_VALID;
    end
    return verdict;
  endfunction

  function automatic bpsc_pkg::key_t pick_in(input bpsc_pkg::key_t lo,
                                             input bpsc_pkg::key_t hi);
    longint          span;
    longint unsigned raw;
    span = longint'(hi) - longint'(lo);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      2: return bpsc_pkg::key_t'(longint'(lo) +
                                 (longint'($urandom_range(0, 3)) % (span + 1)));
      default: begin
        raw = {$urandom, $urandom};
        return bpsc_pkg::key_t'(longint'(lo) + longint'(raw % longint'(span + 1)));
      end
    endcase
  endfunction

  function automatic bpsc_pkg::key_t noise_key();
    case ($urandom_range(0, 5))
      0: return bpsc_pkg::INT_MIN;
      1: return bpsc_pkg::INT_MAX;
      2: return bpsc_pkg::key_t'($signed($urandom_range(0, 20)) - 10);
      default: return bpsc_pkg::key_t'($urandom);
    endcase
  endfunction

  // a key that keeps the sequence a legal preorder; lvl picks how far it pops
  function automatic bpsc_pkg::key_t legal_key(input bit stay_on_top);
    int top;
    int lvl;
    int r;
    top = depth_used - 1;
    r   = $urandom_range(0, 99);
    if (stay_on_top || r < 55) lvl = top;
    else if (r < 85) lvl = top - $urandom_range(0, (top < 3) ? top : 3);
    else lvl = $urandom_range(0, top);
    return pick_in(lo_stk[lvl], hi_stk[lvl]);
  endfunction

  function automatic bpsc_pkg::key_t illegal_key();
    bpsc_pkg::key_t floor_lo;
    floor_lo = lo_stk[depth_used - 1];
    if (floor_lo == bpsc_pkg::INT_MIN) return noise_key();
    return pick_in(bpsc_pkg::INT_MIN, floor_lo - 32'sd1);
  endfunction

  task automatic send_key(input bpsc_pkg::key_t key, input logic eos, input logic typed,
                          input bpsc_pkg::status_t typed_status);
    verdict_t v;
    int       gap;
    in_key_value       <= key;
    in_end_of_sequence <= eos;
    in_valid           <= 1'b1;
    do @(posedge clk); while (!in_ready);
    v.status = preorder_step(key, eos);
    if (typed) v.status = typed_status;
    v.done = eos;
    verdict_q.push_back(v);
    beats_in++;
    if (!calm && send_run == 0) begin
      gap      = $urandom_range(1, 15);
      send_run = $urandom_range(0, 40);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if (send_run > 0) begin
      send_run--;
    end
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int hold_left;
    int stall_left;
    int ready_run;
    hold_left  = 0;
    stall_left = 0;
    ready_run  = 20;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && ready_run == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        ready_run  = $urandom_range(0, 50);
        out_ready <= 1'b0;
      end else begin
        if (ready_run > 0) ready_run--;
        out_ready <= 1'b1;
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: %0d idle cycles, %0d verdicts outstanding", quiet,
                 verdict_q.size());
        $display("Regression FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected beat status=%0d done=%0b", $realtime,
                     out_check_status, out_sequence_done);
        end else begin
          want = verdict_q.pop_front();
          if (out_check_status !== want.status || out_sequence_done !== want.done) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch status exp=%0d got=%0d, done exp=%0b got=%0b",
                       $realtime, want.status, out_check_status, want.done,
                       out_sequence_done);
          end
          if (want.done) begin
            case (want.status)
              bpsc_pkg::STATUS_VALID:        seq_ok++;
              bpsc_pkg::STATUS_NOT_PREORDER: seq_bad++;
              bpsc_pkg::STATUS_OVERFLOW:     seq_ovf++;
              default: ;
            endcase
          end
        end
      end
    end
  end

  initial begin
    int             fresh;
    int             kind;
    int             len;
    int             bad_at;
    int             i;
    bpsc_pkg::key_t key;
    logic           eos;
    clear_stack();
    run_status = bpsc_pkg::STATUS_VALID;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      send_key(dir_rows[r].key, dir_rows[r].eos, dir_rows[r].typed, dir_rows[r].status);

    // random sequences: mostly legal preorders, some driven deep to overflow,
    // some broken mid-way, some plain noise
    fresh = 0;
    while (fresh < ITEMS) begin
      kind   = $urandom_range(0, 99);
      if (kind < 50) len = $urandom_range(1, 40);
      else if (kind < 65) len = $urandom_range(58, 70);
      else if (kind < 85) len = $urandom_range(2, 30);
      else len = $urandom_range(1, 10);
      bad_at = $urandom_range(0, len - 1);
      for (i = 0; i < len; i++) begin
        if (kind < 50) key = legal_key(1'b0);
        else if (kind < 65) key = legal_key(1'b1);
        else if (kind < 85) key = (i == bad_at) ? illegal_key() : legal_key(1'b0);
        else key = noise_key();
        eos = (i == len - 1);
        fresh++;
        send_key(key, eos, 1'b0, bpsc_pkg::STATUS_VALID);
        if (fresh >= HOLD_AT) hold_req = 1'b1;
        if (fresh >= ITEMS - CALM_TAIL) calm = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d key beats; sequences ended valid=%0d, rejected=%0d, overflow=%0d",
             beats_in, seq_ok, seq_bad, seq_ovf);
    $display("Mismatching or unexpected beats: %0d, verdicts left: %0d", fail_cnt,
             verdict_q.size());
    if (fail_cnt == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
